// ===== rtl/cfd_pkg.sv =====
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types and constants for the COBS frame decoder: word formats,
// error codes and the size of the queue between the front and back parts.
// ----------------------------------------------------------------------------
package cfd_pkg;

    // Code byte that starts a run with no implied zero.
    localparam logic [7:0] CODE_FULL_RUN = 8'hFF;
    localparam logic [7:0] CODE_ZERO     = 8'h00;

    // Queue between the decode front and the output back.
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_ZERO_CODE = 2'd1,
        ERR_OVERRUN   = 2'd2,
        ERR_TOO_LONG  = 2'd3
    } t_err;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       block_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        frame_done;
        t_err        error_kind;
        logic [15:0] decoded_length;
    } t_out_item;

    // Queue status seen by the front and back parts.
    typedef struct packed {
        logic full;
        logic nonempty;
    } t_q_stat;

endpackage

// ===== rtl/cobs_frame_decoder_top.sv =====
// ----------------------------------------------------------------------------
// cobs_frame_decoder_top
// COBS block decoder, one encoded word in per cycle while o_stall is low, delimiter stripped.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall / i_in): one encoded byte per word, with
//   block_end set on the last byte of a block. A word is taken at a clock
//   edge with i_valid high and o_stall low.
//   Output channel (o_valid / i_stall / o_out): one word per decoded byte;
//   the final byte of each block always gets a word, which also carries
//   frame_done, error_kind and decoded_length. Other bytes that decode to
//   nothing (code bytes, or anything after an error) produce no word. On an
//   error the bytes already sent belong to a bad block and must be discarded.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): writes the
//   capacity limit; always ready. Write it only while the block is idle.
// Timing:
//   Sustains one input word per cycle while o_stall is low. A result is
//   written into the queue at the edge that accepts its input word, and
//   moves into the output register once that register is free.
// Reset (synchronous, active low): clears the run state, empties the
//   queue and output register, and sets the capacity limit to 65535.
// Stall: the output register holds its word; results collect in a
//   four-word queue, and o_stall rises once that queue is full.
// ----------------------------------------------------------------------------
module cobs_frame_decoder_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // encoded input
    input  logic                i_valid,
    output logic                o_stall,
    input  cfd_pkg::t_in_item   i_in,
    // decoded output
    output logic                o_valid,
    input  logic                i_stall,
    output cfd_pkg::t_out_item  o_out,
    // capacity register write
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [15:0]         i_cfg_data
);

    logic [15:0]        r_max_len;
    logic               push;
    logic               pop;
    cfd_pkg::t_out_item push_item;
    cfd_pkg::t_out_item head;
    cfd_pkg::t_q_stat   q_stat;

    // Capacity register: take every write at once.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= 16'hFFFF;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_len <= i_cfg_data;
        end
    end

    // Front: accept and decode, push results.
    cfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in        (i_in),
        .i_max_len   (r_max_len),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_push_item (push_item)
    );

    // Queue: decouple decode from the output stall.
    cfd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_item (push_item),
        .i_pop       (pop),
        .o_head      (head),
        .o_stat      (q_stat)
    );

    // Back: drive the output register.
    cfd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_head   (head),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_out    (o_out)
    );

endmodule

// ===== rtl/cfd_front.sv =====
// ----------------------------------------------------------------------------
// cfd_front
// Accepts encoded words, tracks the run state of the current block and
// pushes one result word into the queue when a byte is decoded or the
// block ends.
// ----------------------------------------------------------------------------
module cfd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  cfd_pkg::t_in_item   i_in,
    input  logic [15:0]         i_max_len,
    input  cfd_pkg::t_q_stat    i_q_stat,
    output logic                o_push,
    output cfd_pkg::t_out_item  o_push_item
);

    logic [7:0]    r_lit, n_lit;
    logic          r_zp, n_zp;
    logic [15:0]   r_cnt, n_cnt;
    cfd_pkg::t_err r_err, n_err;

    logic          accept;
    logic          dec_valid;
    logic [7:0]    dec_value;
    logic          last;

    assign o_stall = i_q_stat.full;
    assign accept  = i_valid && !i_q_stat.full;
    assign last    = i_in.block_end;

    always_comb begin
        n_lit     = r_lit;
        n_zp      = r_zp;
        n_cnt     = r_cnt;
        n_err     = r_err;
        dec_valid = 1'b0;
        dec_value = 8'd0;
        if (r_err == cfd_pkg::ERR_NONE) begin
            if (r_lit == 8'd0) begin
                // Code byte: release the pending zero first.
                if (r_zp) begin
                    if (r_cnt >= i_max_len) begin
                        n_err = cfd_pkg::ERR_TOO_LONG;
                    end else begin
                        dec_valid = 1'b1;
                        n_cnt     = r_cnt + 16'd1;
                        n_zp      = 1'b0;
                    end
                end
                if (n_err == cfd_pkg::ERR_NONE) begin
                    if (i_in.data_byte == cfd_pkg::CODE_ZERO) begin
                        n_err = cfd_pkg::ERR_ZERO_CODE;
                    end else begin
                        n_lit = i_in.data_byte - 8'd1;
                        n_zp  = (i_in.data_byte != cfd_pkg::CODE_FULL_RUN);
                    end
                end
            end else begin
                if (r_cnt >= i_max_len) begin
                    n_err = cfd_pkg::ERR_TOO_LONG;
                end else begin
                    dec_valid = 1'b1;
                    dec_value = i_in.data_byte;
                    n_cnt     = r_cnt + 16'd1;
                    n_lit     = r_lit - 8'd1;
                end
            end
            if (n_err == cfd_pkg::ERR_NONE && last && n_lit != 8'd0) begin
                n_err = cfd_pkg::ERR_OVERRUN;
            end
            // Drop the byte that raised an error.
            if (n_err != cfd_pkg::ERR_NONE) begin
                dec_valid = 1'b0;
                dec_value = 8'd0;
            end
        end
    end

    always_comb begin
        o_push                     = accept && (last || dec_valid);
        o_push_item.out_byte       = dec_value;
        o_push_item.byte_valid     = dec_valid;
        o_push_item.frame_done     = last;
        o_push_item.error_kind     = last ? n_err : cfd_pkg::ERR_NONE;
        o_push_item.decoded_length =
            (last && n_err == cfd_pkg::ERR_NONE) ? n_cnt : 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lit <= 8'd0;
            r_zp  <= 1'b0;
            r_cnt <= 16'd0;
            r_err <= cfd_pkg::ERR_NONE;
        end else if (accept) begin
            if (last) begin
                r_lit <= 8'd0;
                r_zp  <= 1'b0;
                r_cnt <= 16'd0;
                r_err <= cfd_pkg::ERR_NONE;
            end else begin
                r_lit <= n_lit;
                r_zp  <= n_zp;
                r_cnt <= n_cnt;
                r_err <= n_err;
            end
        end
    end

endmodule

// ===== rtl/cfd_queue.sv =====
// ----------------------------------------------------------------------------
// cfd_queue
// Short register queue of result words between the front and back parts.
// ----------------------------------------------------------------------------
module cfd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  cfd_pkg::t_out_item  i_push_item,
    input  logic                i_pop,
    output cfd_pkg::t_out_item  o_head,
    output cfd_pkg::t_q_stat    o_stat
);

    cfd_pkg::t_out_item            r_mem [cfd_pkg::QDEPTH];
    logic [cfd_pkg::QAW-1:0]       r_wptr;
    logic [cfd_pkg::QAW-1:0]       r_rptr;
    logic [cfd_pkg::QCW-1:0]       r_cnt;
    logic                          do_push;
    logic                          do_pop;

    assign o_stat.full     = (r_cnt == cfd_pkg::QCW'(cfd_pkg::QDEPTH));
    assign o_stat.nonempty = (r_cnt != '0);
    assign o_head          = r_mem[r_rptr];

    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_pop && o_stat.nonempty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/cfd_back.sv =====
// ----------------------------------------------------------------------------
// cfd_back
// Output register: takes the queue head whenever the register is empty or
// its word is being taken, and holds it while the receiver stalls.
// ----------------------------------------------------------------------------
module cfd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cfd_pkg::t_q_stat    i_q_stat,
    input  cfd_pkg::t_out_item  i_head,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output cfd_pkg::t_out_item  o_out
);

    logic               r_valid;
    cfd_pkg::t_out_item r_out;

    assign o_pop   = i_q_stat.nonempty && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_out   = r_out;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

endmodule

// ===== rtl/cfd_checker.sv =====
// ----------------------------------------------------------------------------
// cfd_checker
// Port-level checks on the decoder's result words, bound to the top level.
// ----------------------------------------------------------------------------
module cfd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_stall,
    input cfd_pkg::t_out_item  o_out
);

    // A word that does not close a block always carries a byte.
    a_mid_has_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out.frame_done) |-> o_out.byte_valid)
        else $error("non-final word without a decoded byte");

    // Errors are reported only on the closing word.
    a_err_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.error_kind != cfd_pkg::ERR_NONE) |-> o_out.frame_done)
        else $error("error reported before block end");

    // A length is reported only on a clean closing word.
    a_len_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.decoded_length != 16'd0) |->
        (o_out.frame_done && o_out.error_kind == cfd_pkg::ERR_NONE))
        else $error("length reported outside a clean block end");

    // An error word never carries a byte.
    a_err_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.error_kind != cfd_pkg::ERR_NONE) |-> !o_out.byte_valid)
        else $error("byte emitted with an error");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out)))
        else $error("stalled output word changed");

endmodule

bind cobs_frame_decoder_top cfd_checker u_cfd_checker (.*);

// ===== tb/tb_cobs_frame_decoder_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cobs_frame_decoder_top
// Self-checking bench for the COBS frame decoder. Encoded bytes are queued
// by the stimulus process and driven one word per handshake. A behavioral
// decoder runs on every accepted word and queues the decoded words it owes;
// the monitor checks each output word, field by field, against the oldest
// one. Both channels idle at random, and the capacity limit is changed
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_cobs_frame_decoder_top;

    localparam int CLK_PERIOD  = 10;
    localparam int IDLE_PCT    = 31;     // chance per cycle that a side idles
    localparam int SETTLE_CLKS = 4;      // margin after the last owed word
    localparam int QUIET_LIMIT = 2000;   // cycles with no handshake at all
    localparam int PHASE_WORDS = 180;    // encoded words per random phase
    localparam int PRINT_LIMIT = 50;     // mismatch lines shown

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_valid     = 1'b0;
    logic                o_stall;
    cfd_pkg::t_in_item   i_in        = '0;
    logic                o_valid;
    logic                i_stall     = 1'b0;
    cfd_pkg::t_out_item  o_out;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [15:0]         i_cfg_data  = '0;

    cobs_frame_decoder_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in        (i_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Encoded words waiting to be driven, and decoded words owed by the DUT.
    cfd_pkg::t_in_item  encoded_bytes_q[$];
    cfd_pkg::t_out_item decoded_words_due[$];

    // Behavioral decoder state, mirrors what the DUT must hold per block.
    logic [15:0]   cap_limit   = 16'hFFFF;
    logic [7:0]    run_left    = '0;
    logic          zero_owed   = 1'b0;
    logic [15:0]   emitted_cnt = '0;
    cfd_pkg::t_err err_state   = cfd_pkg::ERR_NONE;

    int  mismatch_count = 0;
    int  quiet_cycles   = 0;
    bit  calm_window    = 1'b0;   // set to suppress idling on both sides

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Advance the behavioral decoder by one encoded byte and queue the word
    // it produces, if any.
    task automatic cobs_decode_byte(input cfd_pkg::t_in_item w);
        cfd_pkg::t_out_item res;
        logic               emit;
        logic [7:0]         value;
        emit  = 1'b0;
        value = '0;
        if (err_state == cfd_pkg::ERR_NONE) begin
            if (run_left == 8'd0) begin
                // Code byte: flush the zero implied by the previous run first.
                if (zero_owed) begin
                    if (emitted_cnt >= cap_limit) begin
                        err_state = cfd_pkg::ERR_TOO_LONG;
                    end else begin
                        emit        = 1'b1;
                        value       = 8'h00;
                        emitted_cnt = emitted_cnt + 16'd1;
                        zero_owed   = 1'b0;
                    end
                end
                if (err_state == cfd_pkg::ERR_NONE) begin
                    if (w.data_byte == cfd_pkg::CODE_ZERO) begin
                        err_state = cfd_pkg::ERR_ZERO_CODE;
                    end else begin
                        run_left  = w.data_byte - 8'd1;
                        zero_owed = (w.data_byte != cfd_pkg::CODE_FULL_RUN);
                    end
                end
            end else begin
                // Literal: capacity wins over a run cut short by block end.
                if (emitted_cnt >= cap_limit) begin
                    err_state = cfd_pkg::ERR_TOO_LONG;
                end else begin
                    emit        = 1'b1;
                    value       = w.data_byte;
                    emitted_cnt = emitted_cnt + 16'd1;
                    run_left    = run_left - 8'd1;
                end
            end
            if (err_state == cfd_pkg::ERR_NONE && w.block_end && run_left != 8'd0)
                err_state = cfd_pkg::ERR_OVERRUN;
            // The byte that raises an error is never emitted.
            if (err_state != cfd_pkg::ERR_NONE) begin
                emit  = 1'b0;
                value = '0;
            end
        end

        res = '0;
        if (w.block_end) begin
            res.out_byte       = emit ? value : 8'h00;
            res.byte_valid     = emit;
            res.frame_done     = 1'b1;
            res.error_kind     = err_state;
            res.decoded_length = (err_state == cfd_pkg::ERR_NONE) ? emitted_cnt : 16'd0;
            decoded_words_due.push_back(res);
            // Every block end starts the next block from scratch.
            run_left    = '0;
            zero_owed   = 1'b0;
            emitted_cnt = '0;
            err_state   = cfd_pkg::ERR_NONE;
        end else if (emit) begin
            res.out_byte   = value;
            res.byte_valid = 1'b1;
            decoded_words_due.push_back(res);
        end
    endtask

    // ------------------------------------------------------------------------
    // Input driver: present the head of the queue, hold it while stalled,
    // and feed each accepted word to the behavioral decoder.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic              nxt_valid;
        cfd_pkg::t_in_item nxt_word;
        logic              skip;
        nxt_valid = i_valid;
        nxt_word  = i_in;
        skip      = !calm_window && ($urandom_range(99) < IDLE_PCT);
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                cobs_decode_byte(i_in);
                void'(encoded_bytes_q.pop_front());
                nxt_valid = 1'b0;
            end
            // A stalled word stays put; otherwise maybe idle this cycle.
            if (!nxt_valid && encoded_bytes_q.size() > 0 && !skip) begin
                nxt_valid = 1'b1;
                nxt_word  = encoded_bytes_q[0];
            end
        end
        i_valid <= nxt_valid;
        i_in    <= nxt_word;
    end

    // ------------------------------------------------------------------------
    // Output monitor: check every accepted word against the oldest owed word,
    // then pick the stall for the next cycle.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        cfd_pkg::t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (decoded_words_due.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", o_out));
            end else begin
                want = decoded_words_due.pop_front();
                if (o_out.out_byte !== want.out_byte)
                    report_mismatch($sformatf("out_byte got %h want %h",
                                              o_out.out_byte, want.out_byte));
                if (o_out.byte_valid !== want.byte_valid)
                    report_mismatch($sformatf("byte_valid got %b want %b",
                                              o_out.byte_valid, want.byte_valid));
                if (o_out.frame_done !== want.frame_done)
                    report_mismatch($sformatf("frame_done got %b want %b",
                                              o_out.frame_done, want.frame_done));
                if (o_out.error_kind !== want.error_kind)
                    report_mismatch($sformatf("error_kind got %0d want %0d",
                                              o_out.error_kind, want.error_kind));
                if (o_out.decoded_length !== want.decoded_length)
                    report_mismatch($sformatf("decoded_length got %0d want %0d",
                                              o_out.decoded_length,
                                              want.decoded_length));
            end
        end
        i_stall <= !calm_window && ($urandom_range(99) < IDLE_PCT);
    end

    // Watchdog: end the run if no channel moves a word for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_word(input logic [7:0] b, input logic last);
        cfd_pkg::t_in_item w;
        w.data_byte = b;
        w.block_end = last;
        encoded_bytes_q.push_back(w);
    endtask

    // Hold off until every owed word has arrived and the pipe has emptied.
    task automatic settle_idle();
        while (encoded_bytes_q.size() > 0 || i_valid || decoded_words_due.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CLKS) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [15:0] limit);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= limit;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cap_limit = limit;
    endtask

    // Build a payload, COBS-encode it and queue it as one block. A nonzero
    // damage kind breaks the block: cut it short, poke a zero code into it,
    // or swap it for raw noise.
    task automatic queue_cobs_block(input int len, input int zero_pct,
                                    input int damage);
        logic [7:0] raw[$];
        logic [7:0] enc[$];
        logic [7:0] code;
        int         code_pos;
        int         cut;
        for (int i = 0; i < len; i++)
            raw.push_back(($urandom_range(99) < zero_pct) ? 8'h00
                                                          : 8'($urandom_range(1, 255)));
        code     = 8'd1;
        code_pos = 0;
        enc.push_back(8'h00);
        foreach (raw[i]) begin
            if (raw[i] == 8'h00) begin
                enc[code_pos] = code;
                code_pos      = enc.size();
                enc.push_back(8'h00);
                code          = 8'd1;
            end else begin
                enc.push_back(raw[i]);
                code = code + 8'd1;
                if (code == cfd_pkg::CODE_FULL_RUN) begin
                    enc[code_pos] = code;
                    code_pos      = enc.size();
                    enc.push_back(8'h00);
                    code          = 8'd1;
                end
            end
        end
        enc[code_pos] = code;

        case (damage)
            1: begin
                if (enc.size() > 1) begin
                    cut = $urandom_range(1, enc.size() - 1);
                    repeat (cut) void'(enc.pop_back());
                end
            end
            2: begin
                enc[$urandom_range(enc.size() - 1)] = cfd_pkg::CODE_ZERO;
            end
            3: begin
                enc.delete();
                repeat ($urandom_range(1, 8)) enc.push_back(8'($urandom));
            end
            default: ;
        endcase

        foreach (enc[i]) queue_word(enc[i], i == enc.size() - 1);
    endtask

    // Random phase: mostly well-formed blocks with random content, the rest
    // damaged blocks.
    task automatic run_random_phase(input logic [15:0] limit);
        int start_words;
        int len;
        int damage;
        write_capacity(limit);
        start_words = 0;
        // Long payloads force full runs; only worth it when they can fit.
        if (limit >= 16'd300) begin
            queue_cobs_block($urandom_range(254, 300), 1, 0);
            start_words = encoded_bytes_q.size();
        end
        while (encoded_bytes_q.size() < start_words + PHASE_WORDS) begin
            len    = ($urandom_range(9) == 0) ? $urandom_range(13, 40)
                                              : $urandom_range(0, 12);
            damage = ($urandom_range(99) < 80) ? 0 : $urandom_range(1, 3);
            queue_cobs_block(len, 30, damage);
        end
        settle_idle();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default capacity from reset.
        queue_word(8'h01, 1'b1);                   // empty block, length 0
        queue_word(cfd_pkg::CODE_ZERO, 1'b1);      // zero code byte
        queue_word(8'h03, 1'b0);                   // block ends inside run
        queue_word(8'h11, 1'b1);
        queue_word(8'h03, 1'b0);                   // literal 00/FF, implied zero
        queue_word(8'h00, 1'b0);
        queue_word(8'hFF, 1'b0);
        queue_word(8'h02, 1'b0);
        queue_word(8'h80, 1'b1);
        queue_word(cfd_pkg::CODE_ZERO, 1'b0);      // bytes after an error drop
        queue_word(8'h05, 1'b0);
        queue_word(8'h01, 1'b1);
        queue_word(cfd_pkg::CODE_FULL_RUN, 1'b1);  // full run cut at once
        settle_idle();

        // No room at all: a literal and a flushed zero both overflow.
        write_capacity(16'd0);
        queue_word(8'h02, 1'b0);
        queue_word(8'h7F, 1'b1);
        queue_word(8'h01, 1'b0);
        queue_word(8'h01, 1'b1);
        settle_idle();

        // Room for one byte: overflow outranks zero code and overrun.
        write_capacity(16'd1);
        queue_word(8'h02, 1'b0);
        queue_word(8'hAA, 1'b0);
        queue_word(cfd_pkg::CODE_ZERO, 1'b1);
        queue_word(8'h03, 1'b0);
        queue_word(8'hAA, 1'b0);
        queue_word(8'hBB, 1'b1);
        queue_word(8'h02, 1'b0);                   // exactly at the limit
        queue_word(8'h55, 1'b1);
        settle_idle();

        run_random_phase(16'hFFFF);
        run_random_phase(16'd4);
        calm_window = 1'b1;                        // back-to-back traffic
        run_random_phase(16'($urandom_range(0, 24)));
        calm_window = 1'b0;
        run_random_phase(16'd0);
        run_random_phase(16'($urandom_range(0, 65535)));

        repeat (SETTLE_CLKS) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
